### hw/rtl/boris_particle_push_macros.svh
// Assertion macros shared by the particle push RTL.
// Every macro expects a clk and an active-low arst_n in the scope where it is used.
`ifndef BORIS_PARTICLE_PUSH_MACROS_SVH
`define BORIS_PARTICLE_PUSH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/bpp_pkg.sv
// Shared types, register map and fixed-point helpers for the particle push block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpp_pkg;

	typedef logic signed [31:0] q_t;
	typedef logic signed [65:0] wide_t;
	typedef logic [2:0][31:0] vec3_t;

	// Register map, decoded on paddr bit 2.
	localparam logic REG_TIME_STEP = 1'b0;
	localparam logic REG_CMR       = 1'b1;

	localparam logic [30:0] TIME_STEP_RST = 31'd655;
	localparam logic [31:0] CMR_RST       = 32'hFFFF_0000;

	// Quotient bits of the s divider; |s| never exceeds 2^32 + 1.
	localparam int DIV_QW = 33;
	// Side payload carried through the divider: position, v1, kick and u.
	localparam int SIDE_W = 12 * 32;

	function automatic wide_t wx(input logic [31:0] a);
		return $signed({{34{a[31]}}, a});
	endfunction

	function automatic q_t sat32(input wide_t v);
		wide_t hi;
		wide_t lo;
		hi = 66'sd2147483647;
		lo = -66'sd2147483648;
		if (v > hi) return 32'sh7FFF_FFFF;
		if (v < lo) return 32'sh8000_0000;
		return q_t'(v[31:0]);
	endfunction

	// floor((p + 2^(sh-1)) / 2^sh)
	function automatic wide_t rnd_shift(input logic signed [63:0] p, input int unsigned sh);
		wide_t x;
		wide_t half;
		half = 66'sd1 <<< (sh - 1);
		x = $signed({{2{p[63]}}, p}) + half;
		return x >>> sh;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/bpp_front.sv
// Front half of the push: electric half kick, rotation vector t, first cross
// product and the divider operands. Four stages. Uses bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "boris_particle_push_macros.svh"

module bpp_front import bpp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           en,
	input  wire                           in_vld,
	input  wire  vec3_t                   pos,
	input  wire  vec3_t                   vel,
	input  wire  vec3_t                   ef,
	input  wire  vec3_t                   bf,
	input  wire  q_t                      h,
	output logic                          vld,
	output logic [(65-FRAC_BITS)+DIV_QW-1:0] num [3],
	output logic [65-FRAC_BITS-1:0]       den,
	output logic [2:0]                    neg,
	output logic [SIDE_W-1:0]             side
);

	localparam int DW = 65 - FRAC_BITS;
	localparam int RW = DW + DIV_QW;
	localparam logic [DW-1:0] DMIN = DW'(1) << FRAC_BITS;

	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	vec3_t         p_s1, p_s2, p_s3, p_s4;
	vec3_t         v_s1, v1_s2, v1_s3, v1_s4;
	vec3_t         k_s1, k_s2, k_s3, k_s4;
	vec3_t         t_s1, t_s2;
	vec3_t         u_s4;
	logic [DW-1:0] tt_s2 [3];
	wide_t         c1_s3 [3];
	wide_t         c2_s3 [3];
	logic [DW-1:0] d_s3, d_s4;
	logic [RW-1:0] mag_s3 [3];
	logic [RW-1:0] num_s4 [3];
	logic [2:0]    neg_s3, neg_s4;

	q_t            k_nx [3];
	q_t            t_nx [3];
	q_t            v1_nx [3];
	logic [DW-1:0] tt_nx [3];
	wide_t         c1_nx [3];
	wide_t         c2_nx [3];
	logic [RW-1:0] mag_nx [3];
	q_t            u_nx [3];
	logic [31:0]   tabs [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int A1 = (i + 1) % 3;
		localparam int A2 = (i + 2) % 3;
		logic signed [63:0] pk, pt, ptt, pc1, pc2;
		wide_t ttw;
		always_comb begin
			pk = $signed(h) * $signed(ef[i]);
			pt = $signed(h) * $signed(bf[i]);
			k_nx[i] = sat32(rnd_shift(pk, FRAC_BITS));
			t_nx[i] = sat32(rnd_shift(pt, FRAC_BITS));
			v1_nx[i] = sat32(wx(v_s1[i]) + wx(k_s1[i]));
			ptt = $signed(t_s1[i]) * $signed(t_s1[i]);
			ttw = rnd_shift(ptt, FRAC_BITS);
			tt_nx[i] = ttw[DW-1:0];
			pc1 = $signed(v1_s2[A1]) * $signed(t_s2[A2]);
			pc2 = $signed(v1_s2[A2]) * $signed(t_s2[A1]);
			c1_nx[i] = rnd_shift(pc1, FRAC_BITS);
			c2_nx[i] = rnd_shift(pc2, FRAC_BITS);
			tabs[i] = t_s2[i][31] ? (~t_s2[i] + 32'd1) : t_s2[i];
			mag_nx[i] = RW'(tabs[i]) << (FRAC_BITS + 1);
			u_nx[i] = sat32(wx(v1_s3[i]) + c1_s3[i] - c2_s3[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= pos;
			v_s1 <= vel;
			for (int i = 0; i < 3; i++) begin
				k_s1[i] <= k_nx[i];
				t_s1[i] <= t_nx[i];
				v1_s2[i] <= v1_nx[i];
				tt_s2[i] <= tt_nx[i];
				c1_s3[i] <= c1_nx[i];
				c2_s3[i] <= c2_nx[i];
				mag_s3[i] <= mag_nx[i];
				neg_s3[i] <= t_s2[i][31];
				u_s4[i] <= u_nx[i];
				num_s4[i] <= mag_s3[i] + RW'(d_s3 >> 1);
			end
			p_s2 <= p_s1;
			k_s2 <= k_s1;
			t_s2 <= t_s1;
			p_s3 <= p_s2;
			k_s3 <= k_s2;
			v1_s3 <= v1_s2;
			d_s3 <= DMIN + tt_s2[0] + tt_s2[1] + tt_s2[2];
			p_s4 <= p_s3;
			k_s4 <= k_s3;
			v1_s4 <= v1_s3;
			d_s4 <= d_s3;
			neg_s4 <= neg_s3;
		end
	end

	assign vld  = vld_s4;
	assign num  = num_s4;
	assign den  = d_s4;
	assign neg  = neg_s4;
	assign side = {p_s4, v1_s4, k_s4, u_s4};

	`BPP_ASSERT_SAME(a_den_floor, vld_s4, d_s4 >= DMIN, "denominator below one")

endmodule

`default_nettype wire

### hw/rtl/bpp_div.sv
// Pipelined restoring divider for the three s components, one quotient bit
// per stage, with the side payload carried alongside. Uses bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "boris_particle_push_macros.svh"

module bpp_div import bpp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 en,
	input  wire                                 in_vld,
	input  wire  [(65-FRAC_BITS)+DIV_QW-1:0]    num [3],
	input  wire  [65-FRAC_BITS-1:0]             den,
	input  wire  [2:0]                          neg,
	input  wire  [SIDE_W-1:0]                   side_in,
	output logic                                vld,
	output vec3_t                               s,
	output logic [SIDE_W-1:0]                   side_out
);

	localparam int DW = 65 - FRAC_BITS;
	localparam int RW = DW + DIV_QW;

	logic              vld_s  [1:DIV_QW];
	logic [RW-1:0]     rem_s  [1:DIV_QW][3];
	logic [DIV_QW-1:0] quo_s  [1:DIV_QW][3];
	logic [DW-1:0]     den_s  [1:DIV_QW];
	logic [2:0]        neg_s  [1:DIV_QW];
	logic [SIDE_W-1:0] side_s [1:DIV_QW];

	logic              vld_slast;
	vec3_t             s_slast;
	logic [SIDE_W-1:0] side_slast;

	logic              vin  [DIV_QW];
	logic [RW-1:0]     rin  [DIV_QW][3];
	logic [DIV_QW-1:0] qin  [DIV_QW][3];
	logic [DW-1:0]     din  [DIV_QW];
	logic [2:0]        nin  [DIV_QW];
	logic [SIDE_W-1:0] sin  [DIV_QW];
	logic [RW-1:0]     dsh  [DIV_QW];
	logic              ge   [DIV_QW][3];
	q_t                s_nx [3];
	wide_t             qw;

	always_comb begin
		for (int j = 0; j < DIV_QW; j++) begin
			if (j == 0) begin
				vin[j] = in_vld;
				din[j] = den;
				nin[j] = neg;
				sin[j] = side_in;
				for (int l = 0; l < 3; l++) begin
					rin[j][l] = num[l];
					qin[j][l] = '0;
				end
			end else begin
				vin[j] = vld_s[j];
				din[j] = den_s[j];
				nin[j] = neg_s[j];
				sin[j] = side_s[j];
				for (int l = 0; l < 3; l++) begin
					rin[j][l] = rem_s[j][l];
					qin[j][l] = quo_s[j][l];
				end
			end
			// Stage j settles quotient bit DIV_QW-1-j.
			dsh[j] = RW'(din[j]) << (DIV_QW - 1 - j);
			for (int l = 0; l < 3; l++) begin
				ge[j][l] = rin[j][l] >= dsh[j];
			end
		end
		for (int l = 0; l < 3; l++) begin
			qw = $signed({33'd0, quo_s[DIV_QW][l]});
			s_nx[l] = sat32(neg_s[DIV_QW][l] ? -qw : qw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 1; j <= DIV_QW; j++) begin
				vld_s[j] <= 1'b0;
			end
			vld_slast <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < DIV_QW; j++) begin
				vld_s[j+1] <= vin[j];
			end
			vld_slast <= vld_s[DIV_QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_QW; j++) begin
				den_s[j+1]  <= din[j];
				neg_s[j+1]  <= nin[j];
				side_s[j+1] <= sin[j];
				for (int l = 0; l < 3; l++) begin
					rem_s[j+1][l] <= ge[j][l] ? (rin[j][l] - dsh[j]) : rin[j][l];
					quo_s[j+1][l] <= {qin[j][l][DIV_QW-2:0], ge[j][l]};
				end
			end
			for (int l = 0; l < 3; l++) begin
				s_slast[l] <= s_nx[l];
			end
			side_slast <= side_s[DIV_QW];
		end
	end

	assign vld      = vld_slast;
	assign s        = s_slast;
	assign side_out = side_slast;

	`BPP_ASSERT_SAME(a_rem_below_den, vld_s[DIV_QW], rem_s[DIV_QW][0] < RW'(den_s[DIV_QW]), "remainder not below divisor")

endmodule

`default_nettype wire

### hw/rtl/bpp_back.sv
// Back half of the push: second cross product, second half kick and the
// position update. Four stages. Uses bpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bpp_back import bpp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                en,
	input  wire                in_vld,
	input  wire  vec3_t        s,
	input  wire  [SIDE_W-1:0]  side,
	input  wire  [30:0]        dt,
	output logic               vld,
	output vec3_t              npos,
	output vec3_t              nvel
);

	vec3_t p_in, v1_in, k_in, u_in;
	assign {p_in, v1_in, k_in, u_in} = side;

	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	vec3_t p_s1, p_s2, p_s3, p_s4;
	vec3_t v1_s1, k_s1;
	wide_t c1_s1 [3];
	wide_t c2_s1 [3];
	vec3_t v3_s2, v3_s3, v3_s4;
	wide_t m_s3 [3];

	wide_t c1_nx [3];
	wide_t c2_nx [3];
	q_t    v3_nx [3];
	wide_t m_nx [3];

	for (genvar i = 0; i < 3; i++) begin : g_lane
		localparam int A1 = (i + 1) % 3;
		localparam int A2 = (i + 2) % 3;
		logic signed [63:0] pc1, pc2, pm;
		q_t v2;
		always_comb begin
			pc1 = $signed(u_in[A1]) * $signed(s[A2]);
			pc2 = $signed(u_in[A2]) * $signed(s[A1]);
			c1_nx[i] = rnd_shift(pc1, FRAC_BITS);
			c2_nx[i] = rnd_shift(pc2, FRAC_BITS);
			v2 = sat32(wx(v1_s1[i]) + c1_s1[i] - c2_s1[i]);
			v3_nx[i] = sat32(wx(v2) + wx(k_s1[i]));
			pm = $signed(v3_s2[i]) * $signed({1'b0, dt});
			m_nx[i] = rnd_shift(pm, FRAC_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1  <= p_in;
			v1_s1 <= v1_in;
			k_s1  <= k_in;
			for (int i = 0; i < 3; i++) begin
				c1_s1[i] <= c1_nx[i];
				c2_s1[i] <= c2_nx[i];
				v3_s2[i] <= v3_nx[i];
				m_s3[i]  <= m_nx[i];
				p_s4[i]  <= sat32(wx(p_s3[i]) + m_s3[i]);
			end
			p_s2  <= p_s1;
			p_s3  <= p_s2;
			v3_s3 <= v3_s2;
			v3_s4 <= v3_s3;
		end
	end

	assign vld  = vld_s4;
	assign npos = p_s4;
	assign nvel = v3_s4;

endmodule

`default_nettype wire

### hw/rtl/boris_particle_push.sv
// Boris particle push, one particle per transfer, signed fixed point.
// Throughput: one particle per cycle while no result waits under out_stall;
// the s divider, with its 33 quotient stages, sets the depth.
// The whole pipeline holds while a result waits under out_stall.
// Reset clears all valid bits and loads time_step = 655 and q/m = -1.0.
`timescale 1ns / 1ps
`default_nettype none
`include "boris_particle_push_macros.svh"

module boris_particle_push import bpp_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [31:0] pos_x,
	input  wire  [31:0] pos_y,
	input  wire  [31:0] pos_z,
	input  wire  [31:0] vel_x,
	input  wire  [31:0] vel_y,
	input  wire  [31:0] vel_z,
	input  wire  [31:0] efield_x,
	input  wire  [31:0] efield_y,
	input  wire  [31:0] efield_z,
	input  wire  [31:0] bfield_x,
	input  wire  [31:0] bfield_y,
	input  wire  [31:0] bfield_z,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [31:0] new_pos_x,
	output logic [31:0] new_pos_y,
	output logic [31:0] new_pos_z,
	output logic [31:0] new_vel_x,
	output logic [31:0] new_vel_y,
	output logic [31:0] new_vel_z
);

	localparam int DW = 65 - FRAC_BITS;
	localparam int RW = DW + DIV_QW;

	logic [30:0] time_step_q;
	logic [31:0] cmr_q;
	logic [30:0] time_step_nx;
	logic [31:0] cmr_nx;
	q_t          h_q;
	logic        wr;
	logic        en;

	function automatic q_t half_factor(input logic [31:0] qm, input logic [30:0] dt);
		logic signed [63:0] pr;
		pr = $signed(qm) * $signed({1'b0, dt});
		return sat32(rnd_shift(pr, FRAC_BITS + 1));
	endfunction

	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CMR) ? cmr_q : {1'b0, time_step_q};

	always_comb begin
		time_step_nx = time_step_q;
		cmr_nx       = cmr_q;
		if (wr) begin
			unique case (paddr[2])
				REG_TIME_STEP: time_step_nx = pwdata[30:0];
				REG_CMR:       cmr_nx       = pwdata;
			endcase
		end
	end

	// The half factor is formed from the incoming register values, so it is
	// current from the same edge as the registers themselves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
			cmr_q       <= CMR_RST;
			h_q         <= half_factor(CMR_RST, TIME_STEP_RST);
		end else begin
			time_step_q <= time_step_nx;
			cmr_q       <= cmr_nx;
			h_q         <= half_factor(cmr_nx, time_step_nx);
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	vec3_t             pos, vel, ef, bf;
	logic              f_vld;
	logic [RW-1:0]     f_num [3];
	logic [DW-1:0]     f_den;
	logic [2:0]        f_neg;
	logic [SIDE_W-1:0] f_side;
	logic              d_vld;
	vec3_t             d_s;
	logic [SIDE_W-1:0] d_side;
	vec3_t             npos, nvel;

	assign pos = {pos_z, pos_y, pos_x};
	assign vel = {vel_z, vel_y, vel_x};
	assign ef  = {efield_z, efield_y, efield_x};
	assign bf  = {bfield_z, bfield_y, bfield_x};

	bpp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(in_valid),
		.pos(pos), .vel(vel), .ef(ef), .bf(bf), .h(h_q),
		.vld(f_vld), .num(f_num), .den(f_den), .neg(f_neg), .side(f_side)
	);

	bpp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(f_vld),
		.num(f_num), .den(f_den), .neg(f_neg), .side_in(f_side),
		.vld(d_vld), .s(d_s), .side_out(d_side)
	);

	bpp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .in_vld(d_vld),
		.s(d_s), .side(d_side), .dt(time_step_q),
		.vld(out_valid), .npos(npos), .nvel(nvel)
	);

	assign new_pos_x = npos[0];
	assign new_pos_y = npos[1];
	assign new_pos_z = npos[2];
	assign new_vel_x = nvel[0];
	assign new_vel_y = nvel[1];
	assign new_vel_z = nvel[2];

	`BPP_ASSERT_NEXT(a_ts_write, wr && (paddr[2] == REG_TIME_STEP),
		time_step_q == $past(pwdata[30:0]), "time step write lost")
	`BPP_ASSERT_SAME(a_h_follows, 1'b1,
		h_q == half_factor(cmr_q, time_step_q), "half factor out of step")

endmodule

`default_nettype wire
